@@ hdl/filament_bending_force_stencil_defines.svh @@
// assertion macros shared by the filament bending force stencil rtl
`ifndef FILAMENT_BENDING_FORCE_STENCIL_DEFINES_SVH
`define FILAMENT_BENDING_FORCE_STENCIL_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define FBFS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// consequence that holds on the clock edge after the antecedent
`define FBFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fbfs_pkg.sv @@
// shared types and constants of the filament bending force stencil
package fbfs_pkg;

    localparam int AXES_DEF        = 3;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_AXES        = 3;
    localparam int FIELD_W         = 32;
    localparam int RIG_W           = 32;
    localparam int FRAC_W          = 16;
    localparam int MAX_RES         = 3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] coord_a;
        logic signed [FIELD_W-1:0] coord_b;
        logic signed [FIELD_W-1:0] coord_c;
        logic signed [FIELD_W-1:0] force_in_a;
        logic signed [FIELD_W-1:0] force_in_b;
        logic signed [FIELD_W-1:0] force_in_c;
        logic                      final_point;
    } point_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] force_out_a;
        logic signed [FIELD_W-1:0] force_out_b;
        logic signed [FIELD_W-1:0] force_out_c;
        logic                      end_of_filament;
    } force_t;

    // what a force cell adds to its held force
    typedef enum logic [1:0] {
        OP_PASS,
        OP_SUB,
        OP_ADD2
    } cell_op_t;

endpackage

@@ hdl/fbfs_scale.sv @@
// one axis lane: second difference times rigidity, rounded and capped, three stages
module fbfs_scale #(
    parameter int VALUE_WIDTH = fbfs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [fbfs_pkg::RIG_W-1:0]        rigidity,
    input  logic signed [VALUE_WIDTH+1:0]     diff,
    output logic signed [VALUE_WIDTH+1:0]     term
);

    localparam int MW  = VALUE_WIDTH + 2;
    localparam int HW  = MW - fbfs_pkg::FRAC_W;
    localparam int PHW = fbfs_pkg::RIG_W + HW;
    localparam int PLW = fbfs_pkg::RIG_W + fbfs_pkg::FRAC_W;
    localparam int QW  = PHW + 1;
    localparam int RW  = PLW + 1 - fbfs_pkg::FRAC_W;

    logic signed [MW-1:0]  diff_reg;
    logic [MW-1:0]         mag;
    logic                  neg_reg;
    logic [PHW-1:0]        phi_reg;
    logic [PLW-1:0]        plo_reg;
    logic [PLW:0]          rnd_sum;
    logic [QW-1:0]         q;
    logic [VALUE_WIDTH:0]  qcap;
    logic [MW-1:0]         tmag;
    logic signed [MW-1:0]  term_next;
    logic signed [MW-1:0]  term_reg;

    // magnitude split into integer and fraction parts
    assign mag = diff_reg[MW-1] ? (MW'(0) - MW'(diff_reg)) : MW'(diff_reg);

    // round to nearest, ties away from zero, on the magnitude
    assign rnd_sum = {1'b0, plo_reg} + (PLW+1)'(1 << (fbfs_pkg::FRAC_W - 1));
    assign q       = QW'(phi_reg) + QW'(rnd_sum[PLW:fbfs_pkg::FRAC_W]);
    assign qcap    = (q > (QW'(1) << VALUE_WIDTH)) ? {1'b1, {VALUE_WIDTH{1'b0}}}
                                                   : q[VALUE_WIDTH:0];
    assign tmag      = MW'(qcap);
    assign term_next = neg_reg ? (MW'(0) - tmag) : tmag;

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff;
            neg_reg  <= diff_reg[MW-1];
            phi_reg  <= PHW'(rigidity) * PHW'(mag[MW-1:fbfs_pkg::FRAC_W]);
            plo_reg  <= PLW'(rigidity) * PLW'(mag[fbfs_pkg::FRAC_W-1:0]);
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

    // rounded width checked against the sum operand
    if (RW > QW) begin : g_bad_width
        $error("rounding width exceeds sum width");
    end

endmodule

@@ hdl/fbfs_cell.sv @@
// one point slot of the force window: held force plus a saturating update
module fbfs_cell #(
    parameter int AXES        = fbfs_pkg::AXES_DEF,
    parameter int VALUE_WIDTH = fbfs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [VALUE_WIDTH-1:0] load_val [AXES],
    input  fbfs_pkg::cell_op_t            op,
    input  logic signed [VALUE_WIDTH+1:0] term     [AXES],
    output logic signed [VALUE_WIDTH-1:0] upd      [AXES]
);

    localparam int SW = VALUE_WIDTH + 3;
    localparam logic signed [SW-1:0] VMAX_S = {4'b0000, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN_S = {4'b1111, {(VALUE_WIDTH-1){1'b0}}};

    logic signed [VALUE_WIDTH-1:0] force_reg [AXES];
    logic signed [SW-1:0]          addend    [AXES];
    logic signed [SW-1:0]          sum       [AXES];

    always_comb begin
        for (int d = 0; d < AXES; d++) begin
            case (op)
                fbfs_pkg::OP_SUB:  addend[d] = SW'(0) - SW'(term[d]);
                fbfs_pkg::OP_ADD2: addend[d] = SW'(term[d]) <<< 1;
                default:           addend[d] = '0;
            endcase
            sum[d] = SW'(force_reg[d]) + addend[d];
            if (sum[d] > VMAX_S) begin
                upd[d] = VMAX_S[VALUE_WIDTH-1:0];
            end else if (sum[d] < VMIN_S) begin
                upd[d] = VMIN_S[VALUE_WIDTH-1:0];
            end else begin
                upd[d] = sum[d][VALUE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            force_reg <= load_val;
        end
    end

endmodule

@@ hdl/filament_bending_force_stencil.sv @@
// top level of the filament bending force stencil
`include "filament_bending_force_stencil_defines.svh"

// takes the points of a filament one transaction at a time and returns their forces
// with the discrete bending term added: for each run of three points a, b, c every
// axis gets t = rigidity * (a + c - 2b), rounded, and the forces of a, b, c receive
// -t, +2t and -t with saturation. a point's force comes out once no later run can
// touch it, so results trail the input by two points and final_point flushes the
// held ones (up to three transactions). one or two point filaments pass through with
// their incoming forces. one point is taken per clock while the last stage is not waiting;
// a result passes difference, multiply, round and cap, and the force cells into a three
// entry output buffer, which raises m_valid. a point that flushes n results waits at
// the last stage until the buffer has room for all n. rigidity is written through cfg_we
// and cfg_wdata while the block is idle, a rule the user keeps, as the block itself does
// not enforce it; there is no clearing pass after reset
module filament_bending_force_stencil #(
    parameter int AXES        = fbfs_pkg::AXES_DEF,
    parameter int VALUE_WIDTH = fbfs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // rigidity register, unsigned q16.16
    input  logic                        cfg_we,
    input  logic [fbfs_pkg::RIG_W-1:0]  cfg_wdata,
    // point transactions
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fbfs_pkg::point_t            s_data,
    // force transactions
    output logic                        m_valid,
    input  logic                        m_ready,
    output fbfs_pkg::force_t            m_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int DW = VW + 2;
    localparam int FW = fbfs_pkg::FIELD_W;
    localparam int XW = ((VW > FW) ? VW : FW) + 1;
    localparam logic signed [XW-1:0] VMAX_W = {{(XW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN_W = {{(XW-VW+1){1'b1}}, {(VW-1){1'b0}}};

    // what a point does once it reaches the force window
    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_SHORT,
        KIND_TRIPLET
    } kind_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic       slot;   // window slot for a stored or short flushed point
        logic [1:0] nres;   // results this point releases
    } ctrl_t;

    // field in range of the value width
    function automatic logic signed [VW-1:0] to_val(input logic signed [FW-1:0] x);
        logic signed [XW-1:0] wide;
        wide = XW'(x);
        if (wide > VMAX_W) begin
            return VMAX_W[VW-1:0];
        end else if (wide < VMIN_W) begin
            return VMIN_W[VW-1:0];
        end
        return wide[VW-1:0];
    endfunction

    // force vector into an output transaction, low field bits of the signed value
    function automatic fbfs_pkg::force_t pack_res(input logic signed [VW-1:0] v [AXES],
                                                  input logic eof);
        fbfs_pkg::force_t r;
        logic [FW-1:0]    o [fbfs_pkg::MAX_AXES];
        for (int d = 0; d < fbfs_pkg::MAX_AXES; d++) begin
            o[d] = '0;
        end
        for (int d = 0; d < AXES; d++) begin
            o[d] = FW'(v[d]);
        end
        r.force_out_a     = o[0];
        r.force_out_b     = o[1];
        r.force_out_c     = o[2];
        r.end_of_filament = eof;
        return r;
    endfunction

    // configuration
    logic [fbfs_pkg::RIG_W-1:0] rigidity_reg;

    // front end: coordinate window and point count
    logic signed [FW-1:0]   raw_c  [fbfs_pkg::MAX_AXES];
    logic signed [FW-1:0]   raw_f  [fbfs_pkg::MAX_AXES];
    logic signed [VW-1:0]   cin    [AXES];
    logic signed [VW-1:0]   fin    [AXES];
    logic signed [DW-1:0]   diff   [AXES];
    logic signed [VW-1:0]   cw0_reg [AXES];
    logic signed [VW-1:0]   cw1_reg [AXES];
    logic [1:0]             seen_reg;
    logic [1:0]             seen_next;
    logic                   accept;
    ctrl_t                  ctrl_in;

    // pipeline
    ctrl_t                  ctrl1_reg;
    ctrl_t                  ctrl2_reg;
    ctrl_t                  ctrl3_reg;
    logic signed [VW-1:0]   force1_reg [AXES];
    logic signed [VW-1:0]   force2_reg [AXES];
    logic signed [DW-1:0]   term3 [AXES];
    logic                   adv;
    logic                   take;
    logic                   trip3;

    // force cells
    fbfs_pkg::cell_op_t     op_outer;
    fbfs_pkg::cell_op_t     op_mid;
    logic                   load0;
    logic                   load1;
    logic signed [VW-1:0]   load0_val [AXES];
    logic signed [VW-1:0]   upd0 [AXES];
    logic signed [VW-1:0]   upd1 [AXES];
    logic signed [VW-1:0]   upd2 [AXES];

    // output buffer
    fbfs_pkg::force_t       res [fbfs_pkg::MAX_RES];
    fbfs_pkg::force_t       obuf_reg  [fbfs_pkg::MAX_RES];
    fbfs_pkg::force_t       obuf_next [fbfs_pkg::MAX_RES];
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    logic [1:0]             base;
    logic [1:0]             widx;
    logic                   pop;

    // ---------------------------------------------------------------- configuration

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rigidity_reg <= '0;
        end else if (cfg_we) begin
            rigidity_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- front end

    assign raw_c[0] = s_data.coord_a;
    assign raw_c[1] = s_data.coord_b;
    assign raw_c[2] = s_data.coord_c;
    assign raw_f[0] = s_data.force_in_a;
    assign raw_f[1] = s_data.force_in_b;
    assign raw_f[2] = s_data.force_in_c;

    // second difference against the two held points, exact in two extra bits
    always_comb begin
        for (int d = 0; d < AXES; d++) begin
            cin[d]  = to_val(raw_c[d]);
            fin[d]  = to_val(raw_f[d]);
            diff[d] = DW'(cw0_reg[d]) + DW'(cin[d]) - (DW'(cw1_reg[d]) <<< 1);
        end
    end

    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    // classify the point by how many are held before it
    always_comb begin
        ctrl_in.valid = accept;
        ctrl_in.slot  = seen_reg[0];
        if (seen_reg == 2'd2) begin
            ctrl_in.kind = KIND_TRIPLET;
            ctrl_in.nres = s_data.final_point ? 2'(fbfs_pkg::MAX_RES) : 2'd1;
        end else if (s_data.final_point) begin
            ctrl_in.kind = KIND_SHORT;
            ctrl_in.nres = seen_reg + 2'd1;
        end else begin
            ctrl_in.kind = KIND_STORE;
            ctrl_in.nres = 2'd0;
        end
        if (s_data.final_point) begin
            seen_next = 2'd0;
        end else if (seen_reg == 2'd2) begin
            seen_next = 2'd2;
        end else begin
            seen_next = seen_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 2'd0;
        end else if (accept) begin
            seen_reg <= seen_next;
        end
    end

    // coordinate window shifts one point per triplet, fills by slot before that
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (seen_reg == 2'd2) begin
                cw0_reg <= cw1_reg;
                cw1_reg <= cin;
            end else if (seen_reg == 2'd0) begin
                cw0_reg <= cin;
            end else begin
                cw1_reg <= cin;
            end
        end
    end

    // ---------------------------------------------------------------- pipeline

    // whole pipeline moves together; the last stage drains into the buffer
    assign take = ctrl3_reg.valid &&
                  ((3'(cnt_reg) + 3'(ctrl3_reg.nres)) <= 3'(fbfs_pkg::MAX_RES));
    assign adv  = !ctrl3_reg.valid || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end else if (adv) begin
            ctrl1_reg <= ctrl_in;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            force1_reg <= fin;
            force2_reg <= force1_reg;
        end
    end

    // one scaling lane per axis, stages in step with the control
    for (genvar d = 0; d < AXES; d++) begin : g_lane
        fbfs_scale #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_scale (
            .aclk     (aclk),
            .en       (adv),
            .rigidity (rigidity_reg),
            .diff     (diff[d]),
            .term     (term3[d])
        );
    end

    // ---------------------------------------------------------------- force cells

    // cell 2 is the newest point (last pipeline stage), cell 1 the middle point,
    // cell 0 the oldest; on a triplet each hands its updated force one step down
    assign trip3    = ctrl3_reg.kind == KIND_TRIPLET;
    assign op_outer = trip3 ? fbfs_pkg::OP_SUB  : fbfs_pkg::OP_PASS;
    assign op_mid   = trip3 ? fbfs_pkg::OP_ADD2 : fbfs_pkg::OP_PASS;

    assign load0 = take && (trip3 || (ctrl3_reg.kind == KIND_STORE && !ctrl3_reg.slot));
    assign load1 = take && (trip3 || (ctrl3_reg.kind == KIND_STORE && ctrl3_reg.slot));

    always_comb begin
        for (int d = 0; d < AXES; d++) begin
            load0_val[d] = trip3 ? upd1[d] : upd2[d];
        end
    end

    fbfs_cell #(
        .AXES        (AXES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell_old (
        .aclk     (aclk),
        .load     (load0),
        .load_val (load0_val),
        .op       (op_outer),
        .term     (term3),
        .upd      (upd0)
    );

    fbfs_cell #(
        .AXES        (AXES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell_mid (
        .aclk     (aclk),
        .load     (load1),
        .load_val (upd2),
        .op       (op_mid),
        .term     (term3),
        .upd      (upd1)
    );

    fbfs_cell #(
        .AXES        (AXES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell_new (
        .aclk     (aclk),
        .load     (adv),
        .load_val (force2_reg),
        .op       (op_outer),
        .term     (term3),
        .upd      (upd2)
    );

    // ---------------------------------------------------------------- results

    // released forces in point order; nres says how many are real
    always_comb begin
        res[0] = pack_res(upd0, 1'b0);
        res[1] = pack_res(upd2, 1'b1);
        res[2] = pack_res(upd2, 1'b1);
        case (ctrl3_reg.kind)
            KIND_SHORT: begin
                if (!ctrl3_reg.slot) begin
                    res[0] = pack_res(upd2, 1'b1);
                end
            end
            KIND_TRIPLET: begin
                res[1] = pack_res(upd1, 1'b0);
            end
            default: begin
            end
        endcase
    end

    assign m_valid = cnt_reg != 2'd0;
    assign m_data  = obuf_reg[0];
    assign pop     = m_valid && m_ready;
    assign base    = cnt_reg - 2'(pop);

    // head drains by shifting, new results land behind what is left
    always_comb begin
        obuf_next = obuf_reg;
        widx      = 2'd0;
        if (pop) begin
            for (int p = 0; p < fbfs_pkg::MAX_RES - 1; p++) begin
                obuf_next[p] = obuf_reg[p+1];
            end
        end
        if (take) begin
            for (int p = 0; p < fbfs_pkg::MAX_RES; p++) begin
                widx = 2'(p) - base;
                if (2'(p) >= base && widx < ctrl3_reg.nres) begin
                    obuf_next[p] = res[widx];
                end
            end
        end
        cnt_next = 2'(3'(cnt_reg) - 3'(pop) + (take ? 3'(ctrl3_reg.nres) : 3'd0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        obuf_reg <= obuf_next;
    end

    // ---------------------------------------------------------------- checks

    `FBFS_ASSERT_ALWAYS(a_seen_range, aclk, aresetn, seen_reg != 2'd3, "point count out of range")
    `FBFS_ASSERT_NEXT(a_final_clears, aclk, aresetn, accept && s_data.final_point, seen_reg == 2'd0, "final point left points held")
    `FBFS_ASSERT_NEXT(a_take_shows, aclk, aresetn, take && ctrl3_reg.nres != 2'd0, m_valid, "released force not offered")
    `FBFS_ASSERT_NEXT(a_accept_enters, aclk, aresetn, accept, ctrl1_reg.valid, "accepted transaction lost at entry")

endmodule
